// ===== src/i2c_master_bit_sequencer_defines.svh =====
// Assertion helpers for the I2C master bit sequencer checkers.
// Each one expects signals named clk and rst_n where it is used.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define I2CM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam logic [7:0] POLL_LIMIT_RESET = 8'd250;

    // Command codes; IDLE marks no running sequence
    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_WAITACK = 3'd3,
        CMD_READ    = 3'd4,
        CMD_IDLE    = 3'd7
    } cmd_t;

    // Request kinds
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       give_ack;
        logic       sda_level;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_item_t;

    // Sequencer state carried from beat to beat
    typedef struct packed {
        cmd_t       active_command;
        logic [2:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] poll_count;
        logic       scl;
        logic       sda;
        logic       ack_choice;
        logic [7:0] rx_last;
    } seq_state_t;

endpackage

`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
`default_nettype none

// Tick-driven I2C master bit sequencer. Every input beat is either one bus
// delay tick or a command, and produces exactly one result beat carrying the
// SCL/SDA levels, busy/done flags, the last read byte and the ack-timeout
// flag. One beat is accepted per clock while in_ready is high; its result is
// registered in the output register as it is accepted. The only thing that
// sets the rate is the single output register: in_ready drops only while a
// result sits there untaken. The poll limit register is written over the cfg
// channel, which is always ready; it resets to 250.
module i2c_master_bit_sequencer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire i2cm_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output i2cm_pkg::out_item_t  out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data
);

    i2cm_pkg::seq_state_t state_reg;
    i2cm_pkg::seq_state_t state_next;
    i2cm_pkg::out_item_t  result_next;
    i2cm_pkg::out_item_t  out_data_reg;
    logic                 out_valid_reg;
    logic [7:0]           poll_limit_reg;
    logic                 in_fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    i2cm_step u_step (
        .cur        (state_reg),
        .item       (in_data),
        .poll_limit (poll_limit_reg),
        .nxt        (state_next),
        .result     (result_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.active_command <= i2cm_pkg::CMD_IDLE;
            state_reg.phase          <= 3'd0;
            state_reg.bit_count      <= 4'd0;
            state_reg.shift_byte     <= 8'd0;
            state_reg.poll_count     <= 8'd0;
            state_reg.scl            <= 1'b1;
            state_reg.sda            <= 1'b1;
            state_reg.ack_choice     <= 1'b0;
            state_reg.rx_last        <= 8'd0;
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    // Poll limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            poll_limit_reg <= i2cm_pkg::POLL_LIMIT_RESET;
        end else if (cfg_valid) begin
            poll_limit_reg <= cfg_data;
        end
    end

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            out_data_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2cm_step.sv =====
`default_nettype none

// One beat of the bus sequencer: next state and the result for that beat
module i2cm_step (
    input  wire i2cm_pkg::seq_state_t cur,
    input  wire i2cm_pkg::in_item_t   item,
    input  wire logic [7:0]           poll_limit,
    output i2cm_pkg::seq_state_t      nxt,
    output i2cm_pkg::out_item_t       result
);

    logic done;
    logic failed;
    logic [3:0] bc_inc;
    logic [7:0] shift_up;

    assign bc_inc   = cur.bit_count + 4'd1;
    assign shift_up = {cur.shift_byte[6:0], 1'b0};

    // Next state
    always_comb
    begin
        nxt    = cur;
        done   = 1'b0;
        failed = 1'b0;
        if (item.req_type == i2cm_pkg::REQ_COMMAND) begin
            if (cur.active_command == i2cm_pkg::CMD_IDLE) begin
                case (i2cm_pkg::cmd_t'(item.command))
                    i2cm_pkg::CMD_START:
                    begin
                        nxt.active_command = i2cm_pkg::CMD_START;
                        nxt.phase = 3'd0;
                        nxt.sda = 1'b1;
                        nxt.scl = 1'b1;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        nxt.active_command = i2cm_pkg::CMD_STOP;
                        nxt.phase = 3'd0;
                        nxt.sda = 1'b0;
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        nxt.active_command = i2cm_pkg::CMD_WRITE;
                        nxt.phase = 3'd0;
                        nxt.shift_byte = item.tx_byte;
                        nxt.bit_count = 4'd0;
                        nxt.sda = item.tx_byte[7];
                    end
                    i2cm_pkg::CMD_WAITACK:
                    begin
                        nxt.active_command = i2cm_pkg::CMD_WAITACK;
                        nxt.phase = 3'd0;
                        nxt.poll_count = 8'd0;
                        nxt.sda = 1'b1;
                    end
                    i2cm_pkg::CMD_READ:
                    begin
                        nxt.active_command = i2cm_pkg::CMD_READ;
                        nxt.phase = 3'd0;
                        nxt.shift_byte = 8'd0;
                        nxt.bit_count = 4'd0;
                        nxt.ack_choice = item.give_ack;
                        nxt.sda = 1'b1;
                        nxt.scl = 1'b1;
                    end
                    default:
                    begin
                        // unknown code: stay idle
                    end
                endcase
            end
        end else begin
            case (cur.active_command)
                i2cm_pkg::CMD_START:
                begin
                    case (cur.phase)
                        3'd0:
                        begin
                            nxt.sda = 1'b0;
                            nxt.phase = 3'd1;
                        end
                        3'd1:
                        begin
                            nxt.scl = 1'b0;
                            nxt.phase = 3'd2;
                        end
                        default: done = 1'b1;
                    endcase
                end
                i2cm_pkg::CMD_STOP:
                begin
                    case (cur.phase)
                        3'd0:
                        begin
                            nxt.scl = 1'b1;
                            nxt.phase = 3'd1;
                        end
                        3'd1:
                        begin
                            nxt.sda = 1'b1;
                            nxt.phase = 3'd2;
                        end
                        default: done = 1'b1;
                    endcase
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    if (cur.phase == 3'd0) begin
                        nxt.scl = 1'b1;
                        nxt.phase = 3'd1;
                    end else begin
                        nxt.scl = 1'b0;
                        nxt.phase = 3'd0;
                        nxt.bit_count = bc_inc;
                        if (bc_inc >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                            // last bit clocked: release SDA
                            nxt.sda = 1'b1;
                            done = 1'b1;
                        end else begin
                            nxt.shift_byte = shift_up;
                            nxt.sda = shift_up[7];
                        end
                    end
                end
                i2cm_pkg::CMD_WAITACK:
                begin
                    case (cur.phase)
                        3'd0:
                        begin
                            nxt.scl = 1'b1;
                            nxt.phase = 3'd1;
                        end
                        3'd1:
                        begin
                            if (!item.sda_level) begin
                                nxt.scl = 1'b0;
                                nxt.phase = 3'd2;
                            end else if (cur.poll_count >= poll_limit) begin
                                // timeout: begin the stop sequence
                                nxt.sda = 1'b0;
                                nxt.phase = 3'd3;
                            end else begin
                                nxt.poll_count = cur.poll_count + 8'd1;
                            end
                        end
                        3'd2: done = 1'b1;
                        3'd3:
                        begin
                            nxt.scl = 1'b1;
                            nxt.phase = 3'd4;
                        end
                        3'd4:
                        begin
                            nxt.sda = 1'b1;
                            nxt.phase = 3'd5;
                        end
                        3'd5:
                        begin
                            nxt.scl = 1'b0;
                            nxt.phase = 3'd6;
                        end
                        default:
                        begin
                            done = 1'b1;
                            failed = 1'b1;
                        end
                    endcase
                end
                i2cm_pkg::CMD_READ:
                begin
                    case (cur.phase)
                        3'd0:
                        begin
                            nxt.shift_byte = {cur.shift_byte[6:0], item.sda_level};
                            nxt.bit_count = bc_inc;
                            nxt.scl = 1'b0;
                            nxt.phase = 3'd1;
                        end
                        3'd1:
                        begin
                            if (cur.bit_count < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                                nxt.scl = 1'b1;
                                nxt.phase = 3'd0;
                            end else begin
                                nxt.sda = ~cur.ack_choice;
                                nxt.phase = 3'd2;
                            end
                        end
                        3'd2:
                        begin
                            nxt.scl = 1'b1;
                            nxt.phase = 3'd3;
                        end
                        3'd3:
                        begin
                            nxt.scl = 1'b0;
                            nxt.phase = 3'd4;
                        end
                        3'd4:
                        begin
                            if (cur.ack_choice) begin
                                nxt.sda = 1'b1;
                                nxt.phase = 3'd5;
                            end else begin
                                nxt.rx_last = cur.shift_byte;
                                done = 1'b1;
                            end
                        end
                        default:
                        begin
                            nxt.rx_last = cur.shift_byte;
                            done = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    // idle tick: nothing moves
                end
            endcase
            if (done) begin
                nxt.active_command = i2cm_pkg::CMD_IDLE;
                nxt.phase = 3'd0;
            end
        end
    end

    // Result fields
    always_comb
    begin
        result.scl_drive  = nxt.scl;
        result.sda_drive  = nxt.sda;
        result.busy_res   = (nxt.active_command != i2cm_pkg::CMD_IDLE);
        result.done_res   = done;
        result.rx_byte    = nxt.rx_last;
        result.ack_failed = failed;
    end

endmodule

`default_nettype wire

// ===== src/i2cm_checker.sv =====
`default_nettype none

`include "i2c_master_bit_sequencer_defines.svh"

// Port-level checks for the I2C master bit sequencer
module i2cm_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      in_valid,
    input wire                      in_ready,
    input wire                      out_valid,
    input wire                      out_ready,
    input wire i2cm_pkg::out_item_t out_data
);

    // a stalled result beat holds
    `I2CM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // no new input while a result is stuck
    `I2CM_ASSERT_IMPL(a_in_blocked, out_valid && !out_ready, !in_ready, "input taken over a stalled result")

    // every accepted input gives a result next cycle
    `I2CM_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid, "accepted beat gave no result")

    // a timeout is reported only on the finishing beat, which leaves the block idle
    `I2CM_ASSERT_IMPL(a_fail_done, out_valid && out_data.ack_failed, out_data.done_res && !out_data.busy_res, "ack failure off the done beat")

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
